// ===== hw/rtl/esd_pkg.sv =====
// Package for the escape sequence decoder.
// Holds the transfer payload types, the status codes and the character codes.
// Depends on nothing else.
package esd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       string_done;
    } t_out_item;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ESC   = 2'd1;
    localparam logic [1:0] ST_PREMATURE = 2'd2;
    localparam logic [1:0] ST_BAD_HEX   = 2'd3;

    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_QUOTE     = 8'h27;
    localparam logic [7:0] CHR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHR_QUESTION  = 8'h3F;
    localparam logic [7:0] CHR_LC_A      = 8'h61;
    localparam logic [7:0] CHR_LC_B      = 8'h62;
    localparam logic [7:0] CHR_LC_F      = 8'h66;
    localparam logic [7:0] CHR_LC_N      = 8'h6E;
    localparam logic [7:0] CHR_LC_R      = 8'h72;
    localparam logic [7:0] CHR_LC_T      = 8'h74;
    localparam logic [7:0] CHR_LC_V      = 8'h76;
    localparam logic [7:0] CHR_LC_X      = 8'h78;
    localparam logic [7:0] CHR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHR_DIGIT_7   = 8'h37;
    localparam logic [7:0] CHR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHR_UC_A      = 8'h41;
    localparam logic [7:0] CHR_UC_F      = 8'h46;

    localparam logic [7:0] CTL_BEL = 8'd7;
    localparam logic [7:0] CTL_BS  = 8'd8;
    localparam logic [7:0] CTL_HT  = 8'd9;
    localparam logic [7:0] CTL_LF  = 8'd10;
    localparam logic [7:0] CTL_VT  = 8'd11;
    localparam logic [7:0] CTL_FF  = 8'd12;
    localparam logic [7:0] CTL_CR  = 8'd13;

endpackage

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Escape sequence decoder top level: decodes C escape codes in a byte stream.
// Depends on esd_pkg for payload types, status codes and character codes.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
// Each byte is decoded in the cycle it is accepted, and its result, if any,
// appears in the output register on the next cycle.
// One byte is accepted per cycle while the output register is empty or being taken.
// The input side stalls only while a result waits in the output register.
// Reset is synchronous and active low; it returns the decoder to plain characters.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_ESC  = 5'b00010,
        MODE_OCT  = 5'b00100,
        MODE_HEX  = 5'b01000,
        MODE_DROP = 5'b10000
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [1:0] r_digits, n_digits;
    logic [8:0] r_accum, n_accum;
    logic       r_still, n_still;
    logic       r_hbad, n_hbad;

    logic       r_out_valid;
    t_out_item  r_out;

    logic       in_fire;
    logic       res_emit;
    t_out_item  res;

    logic [7:0] b;
    logic       last;
    logic       is_oct;
    logic [2:0] oct_val;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       simple_ok;
    logic [7:0] simple_val;
    logic [1:0] digits_inc;
    logic [8:0] oct_accum;

    assign b    = i_in_data.in_byte;
    assign last = i_in_data.last_byte;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign is_oct  = (b >= CHR_DIGIT_0) && (b <= CHR_DIGIT_7);
    assign oct_val = b[2:0];

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= CHR_DIGIT_0 && b <= CHR_DIGIT_9) begin
            hex_val = 4'(b - CHR_DIGIT_0);
        end else if (b >= CHR_LC_A && b <= CHR_LC_F) begin
            hex_val = 4'(b - CHR_LC_A + 8'd10);
        end else if (b >= CHR_UC_A && b <= CHR_UC_F) begin
            hex_val = 4'(b - CHR_UC_A + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        simple_ok  = 1'b1;
        simple_val = b;
        unique case (b)
            CHR_LC_A: simple_val = CTL_BEL;
            CHR_LC_B: simple_val = CTL_BS;
            CHR_LC_F: simple_val = CTL_FF;
            CHR_LC_N: simple_val = CTL_LF;
            CHR_LC_R: simple_val = CTL_CR;
            CHR_LC_T: simple_val = CTL_HT;
            CHR_LC_V: simple_val = CTL_VT;
            CHR_BACKSLASH, CHR_QUOTE, CHR_DQUOTE, CHR_QUESTION: simple_val = b;
            default: simple_ok = 1'b0;
        endcase
    end

    assign digits_inc = r_digits + 2'd1;
    assign oct_accum  = {r_accum[5:0], 3'b000} + {6'd0, oct_val};

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_accum  = r_accum;
        n_still  = r_still;
        n_hbad   = r_hbad;
        res_emit = 1'b0;
        res      = '{out_byte: 8'd0, status: ST_OK, string_done: last};

        unique case (r_mode)
            MODE_ESC: begin
                if (simple_ok) begin
                    n_mode       = MODE_IDLE;
                    res_emit     = 1'b1;
                    res.out_byte = simple_val;
                end else if (is_oct && !last) begin
                    n_mode   = MODE_OCT;
                    n_digits = 2'd1;
                    n_accum  = {6'd0, oct_val};
                    n_still  = 1'b1;
                    n_hbad   = 1'b0;
                end else if (b == CHR_LC_X && !last) begin
                    n_mode   = MODE_HEX;
                    n_digits = 2'd0;
                    n_accum  = 9'd0;
                    n_still  = 1'b1;
                    n_hbad   = 1'b0;
                end else begin
                    res_emit = 1'b1;
                    res.status = (is_oct || b == CHR_LC_X) ? ST_PREMATURE : ST_BAD_ESC;
                end
            end
            MODE_OCT: begin
                n_digits = digits_inc;
                if (r_still && is_oct) begin
                    n_accum = oct_accum;
                end else begin
                    n_still = 1'b0;
                end
                if (digits_inc == 2'd3) begin
                    res_emit     = 1'b1;
                    res.out_byte = n_accum[7:0];
                    n_mode       = MODE_IDLE;
                    n_digits     = 2'd0;
                    n_accum      = 9'd0;
                    n_still      = 1'b1;
                    n_hbad       = 1'b0;
                end else if (last) begin
                    res_emit   = 1'b1;
                    res.status = ST_PREMATURE;
                end
            end
            MODE_HEX: begin
                if (r_digits == 2'd0) begin
                    n_digits = 2'd1;
                    if (hex_ok) begin
                        n_accum = {5'd0, hex_val};
                    end else begin
                        n_hbad  = 1'b1;
                        n_still = 1'b0;
                    end
                    if (last) begin
                        res_emit   = 1'b1;
                        res.status = ST_PREMATURE;
                    end
                end else if (r_hbad) begin
                    res_emit   = 1'b1;
                    res.status = ST_BAD_HEX;
                end else begin
                    res_emit     = 1'b1;
                    res.out_byte = (r_still && hex_ok) ? {r_accum[3:0], hex_val}
                                                       : r_accum[7:0];
                    n_mode       = MODE_IDLE;
                    n_digits     = 2'd0;
                    n_accum      = 9'd0;
                    n_still      = 1'b1;
                    n_hbad       = 1'b0;
                end
            end
            MODE_DROP: begin
                if (last) begin
                    n_mode   = MODE_IDLE;
                    n_digits = 2'd0;
                    n_accum  = 9'd0;
                    n_still  = 1'b1;
                    n_hbad   = 1'b0;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (b == CHR_BACKSLASH) begin
                    if (last) begin
                        res_emit   = 1'b1;
                        res.status = ST_PREMATURE;
                    end else begin
                        n_mode = MODE_ESC;
                    end
                end else begin
                    res_emit     = 1'b1;
                    res.out_byte = b;
                end
            end
        endcase

        // Every error result ends the string and clears the digit state.
        if (res_emit && res.status != ST_OK) begin
            res.out_byte    = 8'd0;
            res.string_done = 1'b1;
            n_mode          = last ? MODE_IDLE : MODE_DROP;
            n_digits        = 2'd0;
            n_accum         = 9'd0;
            n_still         = 1'b1;
            n_hbad          = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_digits    <= 2'd0;
            r_accum     <= 9'd0;
            r_still     <= 1'b1;
            r_hbad      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_mode      <= n_mode;
                r_digits    <= n_digits;
                r_accum     <= n_accum;
                r_still     <= n_still;
                r_hbad      <= n_hbad;
                r_out_valid <= res_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_emit) begin
            r_out <= res;
        end
    end

`ifndef SYNTHESIS
    a_error_ends_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK |-> r_out.string_done && r_out.out_byte == 8'd0)
        else $error("An error result does not end the string with a zero byte.");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && last |=> r_mode == MODE_IDLE)
        else $error("The decoder is not idle after the last byte of a string.");

    a_drop_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_mode == MODE_DROP |=> !r_out_valid)
        else $error("A dropped byte produced a result.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !in_fire)
        else $error("A new byte was accepted while a result was stalled.");
`endif

endmodule

// ===== dv/escape_sequence_decoder_tb.sv =====
// Testbench for the escape sequence decoder: directed strings, then random escaped strings.
// A predictor in the bench computes the decoded bytes and status codes each result is checked
// against. Depends on esd_pkg and escape_sequence_decoder.
module escape_sequence_decoder_tb;
    import esd_pkg::*;

    typedef enum logic [2:0] {
        SCAN_PLAIN,
        SCAN_ESC,
        SCAN_OCT,
        SCAN_HEX,
        SCAN_SKIP
    } t_scan_mode;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PERCENT = 14;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;

    t_scan_mode scan_mode = SCAN_PLAIN;
    logic [1:0] dig_count = '0;
    logic [8:0] dig_accum = '0;
    logic       dig_ok = 1'b1;
    logic       hex_lead_bad = 1'b0;

    t_out_item decoded_q[$];
    int        bytes_sent = 0;
    int        results_seen = 0;
    int        status_hits[4] = '{0, 0, 0, 0};
    int        err_count = 0;
    int        quiet_cycles = 0;

    logic [7:0] esc_letters[11] = '{CHR_LC_A, CHR_LC_B, CHR_LC_F, CHR_LC_N, CHR_LC_R,
        CHR_LC_T, CHR_LC_V, CHR_BACKSLASH, CHR_QUOTE, CHR_DQUOTE, CHR_QUESTION};

    escape_sequence_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic bit is_oct(logic [7:0] c);
        return c >= CHR_DIGIT_0 && c <= CHR_DIGIT_7;
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            return int'(c) - int'(CHR_DIGIT_0);
        end
        if (c >= CHR_LC_A && c <= CHR_LC_F) begin
            return int'(c) - int'(CHR_LC_A) + 10;
        end
        if (c >= CHR_UC_A && c <= CHR_UC_F) begin
            return int'(c) - int'(CHR_UC_A) + 10;
        end
        return -1;
    endfunction

    function automatic int simple_esc_value(logic [7:0] c);
        case (c)
            CHR_LC_A: return CTL_BEL;
            CHR_LC_B: return CTL_BS;
            CHR_LC_F: return CTL_FF;
            CHR_LC_N: return CTL_LF;
            CHR_LC_R: return CTL_CR;
            CHR_LC_T: return CTL_HT;
            CHR_LC_V: return CTL_VT;
            CHR_BACKSLASH, CHR_QUOTE, CHR_DQUOTE, CHR_QUESTION: return c;
            default: return -1;
        endcase
    endfunction

    function automatic void push_decoded(logic [7:0] b, logic [1:0] st, logic done);
        t_out_item r;
        r.out_byte = b;
        r.status = st;
        r.string_done = done;
        decoded_q.push_back(r);
    endfunction

    function automatic void clear_digits();
        dig_count = '0;
        dig_accum = '0;
        dig_ok = 1'b1;
        hex_lead_bad = 1'b0;
    endfunction

    function automatic void flag_error(logic [1:0] st, logic lst);
        clear_digits();
        scan_mode = lst ? SCAN_PLAIN : SCAN_SKIP;
        push_decoded(8'h00, st, 1'b1);
    endfunction

    // Advances the predicted decoder state by one accepted character.
    function automatic void decode_char(logic [7:0] b, logic lst);
        int v;
        case (scan_mode)
            SCAN_ESC: begin
                v = simple_esc_value(b);
                if (v >= 0) begin
                    scan_mode = SCAN_PLAIN;
                    push_decoded(v[7:0], ST_OK, lst);
                end else if (is_oct(b)) begin
                    if (lst) begin
                        flag_error(ST_PREMATURE, lst);
                    end else begin
                        clear_digits();
                        dig_accum = {6'd0, b[2:0]};
                        dig_count = 2'd1;
                        scan_mode = SCAN_OCT;
                    end
                end else if (b == CHR_LC_X) begin
                    if (lst) begin
                        flag_error(ST_PREMATURE, lst);
                    end else begin
                        clear_digits();
                        scan_mode = SCAN_HEX;
                    end
                end else begin
                    flag_error(ST_BAD_ESC, lst);
                end
            end
            SCAN_OCT: begin
                if (dig_ok && is_oct(b)) begin
                    dig_accum = {dig_accum[5:0], b[2:0]};
                end else begin
                    dig_ok = 1'b0;
                end
                dig_count = dig_count + 2'd1;
                if (dig_count == 2'd3) begin
                    push_decoded(dig_accum[7:0], ST_OK, lst);
                    clear_digits();
                    scan_mode = SCAN_PLAIN;
                end else if (lst) begin
                    flag_error(ST_PREMATURE, lst);
                end
            end
            SCAN_HEX: begin
                v = hex_val(b);
                if (dig_count == 2'd0) begin
                    if (v < 0) begin
                        hex_lead_bad = 1'b1;
                        dig_ok = 1'b0;
                    end else begin
                        dig_accum = 9'(v);
                    end
                    dig_count = 2'd1;
                    if (lst) begin
                        flag_error(ST_PREMATURE, lst);
                    end
                end else if (hex_lead_bad) begin
                    flag_error(ST_BAD_HEX, lst);
                end else begin
                    if (dig_ok && v >= 0) begin
                        dig_accum = {dig_accum[4:0], v[3:0]};
                    end
                    push_decoded(dig_accum[7:0], ST_OK, lst);
                    clear_digits();
                    scan_mode = SCAN_PLAIN;
                end
            end
            SCAN_SKIP: begin
                if (lst) begin
                    clear_digits();
                    scan_mode = SCAN_PLAIN;
                end
            end
            default: begin
                scan_mode = SCAN_PLAIN;
                if (b == CHR_BACKSLASH) begin
                    if (lst) begin
                        flag_error(ST_PREMATURE, lst);
                    end else begin
                        scan_mode = SCAN_ESC;
                    end
                end else begin
                    push_decoded(b, ST_OK, lst);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Called at a rising edge; returns at the edge where the character is transferred.
    task automatic send_char(input logic [7:0] b, input logic lst);
        while (in_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{in_byte: b, last_byte: lst};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        decode_char(b, lst);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_oct_char();
        if ($urandom_range(0, 9) < 8) begin
            return CHR_DIGIT_0 + 8'($urandom_range(0, 7));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int sel;
        if ($urandom_range(0, 99) >= 85) begin
            return 8'($urandom_range(0, 255));
        end
        sel = $urandom_range(0, 21);
        if (sel < 10) begin
            return CHR_DIGIT_0 + 8'(sel);
        end
        if (sel < 16) begin
            return CHR_LC_A + 8'(sel - 10);
        end
        return CHR_UC_A + 8'(sel - 16);
    endfunction

    function automatic logic [7:0] rand_bad_esc_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (simple_esc_value(c) >= 0 || is_oct(c) || c == CHR_LC_X);
        return c;
    endfunction

    // Builds and sends one string of random characters and mostly well-formed escapes, sometimes cut short.
    task automatic send_random_string();
        logic [7:0] chars[$];
        int kind;
        int cut;
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                chars.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 55) begin
                chars.push_back(CHR_BACKSLASH);
                chars.push_back(esc_letters[$urandom_range(0, 10)]);
            end else if (kind < 70) begin
                chars.push_back(CHR_BACKSLASH);
                chars.push_back(CHR_DIGIT_0 + 8'($urandom_range(0, 7)));
                chars.push_back(rand_oct_char());
                chars.push_back(rand_oct_char());
            end else if (kind < 85) begin
                chars.push_back(CHR_BACKSLASH);
                chars.push_back(CHR_LC_X);
                chars.push_back(rand_hex_char());
                chars.push_back(rand_hex_char());
            end else if (kind < 93) begin
                chars.push_back(CHR_BACKSLASH);
                chars.push_back(rand_bad_esc_char());
            end else begin
                chars.push_back(CHR_BACKSLASH);
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, chars.size());
            chars = chars[0:cut - 1];
        end
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic test_plain_extremes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_escape_forms();
        send_text("\\n\\\"");
        send_text("\\777\\1z9");
        send_text("\\xfF");
    endtask

    task automatic test_error_cases();
        send_text("\\xg0");
        send_text("\\xg");
        send_text("\\q");
        send_text("\\qab");
        send_text("\\");
    endtask

    task automatic test_random_strings(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            send_random_string();
        end
    endtask

    task automatic test_back_to_back(input int count);
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        test_random_strings(count);
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            status_hits[out_data.status]++;
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", out_data));
            end else begin
                want = decoded_q.pop_front();
                if (out_data.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                        out_data.out_byte, want.out_byte));
                end
                if (out_data.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                        out_data.status, want.status));
                end
                if (out_data.string_done !== want.string_done) begin
                    report_mismatch($sformatf("string_done %b, expected %b",
                        out_data.string_done, want.string_done));
                end
            end
        end
        out_ready <= !(out_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Stalled for %0d cycles with %0d results pending.",
                quiet_cycles, decoded_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_extremes();
        test_escape_forms();
        test_error_cases();
        test_random_strings(1000);
        test_back_to_back(400);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d characters and checked %0d decoded results.", bytes_sent,
            results_seen);
        $display("Status mix: %0d ok, %0d bad escape, %0d cut short, %0d bad hex.",
            status_hits[ST_OK], status_hits[ST_BAD_ESC], status_hits[ST_PREMATURE],
            status_hits[ST_BAD_HEX]);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/esd_pkg.sv
hw/rtl/escape_sequence_decoder.sv
dv/escape_sequence_decoder_tb.sv
